// File: rtl/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Types and codes shared by the call chain fold table and its users.
// ----------------------------------------------------------------------------
`default_nettype none

package ccf_pkg;

  // Input actions. The reserved code is ignored by the table.
  localparam logic [1:0] ACT_SAMPLE   = 2'd0;
  localparam logic [1:0] ACT_REPORT   = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CALLER = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PID_FILTER_ON = 2'd0;
  localparam logic [1:0] CFG_PID_FILTER    = 2'd1;
  localparam logic [1:0] CFG_CHAIN_LIMIT   = 2'd2;

  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned LIMIT_W        = 9;
  localparam logic [8:0]  LIMIT_RESET    = 9'd256;
  localparam int unsigned PERMILLE_SCALE = 1000;
  localparam int unsigned PROD_W         = 42;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pid;
    logic [15:0] leaf_symbol;
    logic [31:0] leaf_offset;
    logic [63:0] frame_address;
    logic        last_frame;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  chain_depth;
    logic [31:0] hits;
    logic [9:0]  permille;
    logic [15:0] symbol_out;
    logic [31:0] offset_low;
    logic [31:0] offset_high;
    logic [63:0] caller_address;
    logic [31:0] total_seen;
    logic [31:0] unfolded_seen;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/call_chain_fold_table.sv
// ----------------------------------------------------------------------------
// call_chain_fold_table
// Folds profiler stack samples into a table of call chains in memory and
// reports the chains hottest first, one selection step per report.
// ----------------------------------------------------------------------------
// The last frame of a sample starts a fold: the pid filter check, then a walk
// of the table through the single header read port, a read and a compare per
// entry, plus a read and a compare per caller address on entries whose depth
// and symbol match, then an update of a matching entry, or a header write and
// a write per caller copied into a new entry. A report past the used entries
// or the chain limit gives a done result; else it selects over each entry from
// the current rank to the end of the table, swaps when needed, runs the
// multiply and the bit-serial permille division, then gives the header result
// and one result per caller. Results appear on result_o with result_valid_o
// high for exactly one cycle each; they cannot be stalled. busy is high from
// an accepted last frame or report until the fold ends or its last result has
// been shown. No clearing pass is needed after reset.
`default_nettype none

module call_chain_fold_table #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned MAX_FRAMES  = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire ccf_pkg::in_t                        item_i,
  output logic                                     result_valid_o,
  output ccf_pkg::out_t                            result_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [ccf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned UW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned FW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CAD = MAX_ENTRIES * MAX_FRAMES;
  localparam int unsigned CAW = (CAD > 1) ? $clog2(CAD) : 1;
  localparam int unsigned CW  = (UW > ccf_pkg::LIMIT_W) ? UW : ccf_pkg::LIMIT_W;
  localparam int unsigned PW  = ccf_pkg::PROD_W;

  typedef struct packed {
    logic [FW-1:0] depth;
    logic [15:0]   symbol;
    logic [31:0]   low;
    logic [31:0]   high;
    logic [31:0]   hits;
  } hdr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FOLD, S_SC_RD, S_SC_CMP, S_CL_RD, S_CL_CMP, S_HIT, S_MISS, S_CP,
    S_REP, S_SEL0, S_SEL_RD, S_SEL_CMP, S_SW_H1, S_SW_H2, S_SW_RD, S_SW_WA,
    S_SW_WB, S_MUL, S_DIV, S_HDR, S_CALL
  } state_e;

  function automatic logic [CAW-1:0] caddr(input logic [UW-1:0] ent,
                                           input logic [FW-1:0] fr);
    return CAW'(ent[EW-1:0]) * CAW'(MAX_FRAMES) + CAW'(fr);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Memories.
  hdr_t        hdr_mem [MAX_ENTRIES];
  logic [63:0] cal_mem [CAD];
  logic [63:0] pcall_q [MAX_FRAMES];

  hdr_t           hdr_rd_q;
  logic [63:0]    cal_rd_a_q;
  logic [63:0]    cal_rd_b_q;
  logic [EW-1:0]  hdr_ra;
  logic           hdr_we;
  logic [EW-1:0]  hdr_wa;
  hdr_t           hdr_wd;
  logic [CAW-1:0] cal_ra_a;
  logic [CAW-1:0] cal_ra_b;
  logic           cal_we;
  logic [CAW-1:0] cal_wa;
  logic [63:0]    cal_wd;

  // Control and counters.
  state_e         state_q;
  logic           filt_on_q;
  logic [15:0]    filt_pid_q;
  logic [8:0]     limit_q;
  logic [UW-1:0]  used_q;
  logic [UW-1:0]  rank_q;
  logic [UW-1:0]  e_q;
  logic [UW-1:0]  best_q;
  logic [FW-1:0]  f_q;
  logic [FW-1:0]  plen_q;
  logic [15:0]    ppid_q;
  logic [15:0]    psym_q;
  logic [31:0]    poff_q;
  logic [31:0]    total_q;
  logic [31:0]    unfold_q;
  hdr_t           bhdr_q;
  hdr_t           rhdr_q;
  logic [PW-1:0]  dvd_q;
  logic [31:0]    rem_q;
  logic [5:0]     dcnt_q;
  logic           res_valid_q;
  ccf_pkg::out_t  res_q;

  logic           accept;
  logic           pc_we;
  logic [FW-1:0]  f_inc;
  logic [FW-1:0]  dsel;
  logic [32:0]    trial;
  logic           ge;
  logic [9:0]     pm;
  hdr_t           hit_hdr;
  logic           rep_done;

  assign busy           = (state_q != S_IDLE);
  assign accept         = start && !busy;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;
  assign f_inc          = f_q + FW'(1);

  assign pc_we = accept && (item_i.action == ccf_pkg::ACT_SAMPLE) &&
                 (plen_q != '0) && (plen_q < FW'(MAX_FRAMES));

  assign dsel = (bhdr_q.depth == '0 || bhdr_q.depth > FW'(MAX_FRAMES)) ?
                FW'(1) : bhdr_q.depth;

  // One restoring division step a cycle; the quotient shifts into dvd_q.
  assign trial = {rem_q, dvd_q[PW-1]};
  assign ge    = (trial >= {1'b0, total_q});
  assign pm    = (total_q == '0) ? 10'd0 :
                 (dvd_q > PW'(ccf_pkg::PERMILLE_SCALE)) ?
                 10'(ccf_pkg::PERMILLE_SCALE) : dvd_q[9:0];

  assign rep_done = (CW'(rank_q) >= CW'(used_q)) || (CW'(rank_q) >= CW'(limit_q));

  always_comb begin
    hit_hdr      = bhdr_q;
    hit_hdr.low  = (poff_q < bhdr_q.low) ? poff_q : bhdr_q.low;
    hit_hdr.high = (poff_q > bhdr_q.high) ? poff_q : bhdr_q.high;
    hit_hdr.hits = sat_inc(bhdr_q.hits);
  end

  // Memory port control.
  always_comb begin
    hdr_ra   = e_q[EW-1:0];
    hdr_we   = 1'b0;
    hdr_wa   = e_q[EW-1:0];
    hdr_wd   = hit_hdr;
    cal_ra_a = caddr(e_q, f_q);
    cal_ra_b = caddr(best_q, f_q);
    cal_we   = 1'b0;
    cal_wa   = caddr(e_q, f_q);
    cal_wd   = pcall_q[f_q[FIW-1:0]];
    case (state_q)
      S_HIT: begin
        hdr_we = 1'b1;
      end
      S_MISS: begin
        hdr_we = (CW'(used_q) < CW'(MAX_ENTRIES));
        hdr_wd = '{depth: plen_q, symbol: psym_q, low: poff_q, high: poff_q,
                   hits: 32'd1};
      end
      S_CP: begin
        cal_we = 1'b1;
      end
      S_REP: begin
        hdr_ra = rank_q[EW-1:0];
      end
      S_SW_H1: begin
        hdr_we = 1'b1;
        hdr_wa = rank_q[EW-1:0];
        hdr_wd = bhdr_q;
      end
      S_SW_H2: begin
        hdr_we = 1'b1;
        hdr_wa = best_q[EW-1:0];
        hdr_wd = rhdr_q;
      end
      S_SW_RD: begin
        cal_ra_a = caddr(rank_q, f_q);
      end
      S_SW_WA: begin
        // Keep reading the old rank address so cal_rd_a_q still holds its old word in S_SW_WB.
        cal_ra_a = caddr(rank_q, f_q);
        cal_we   = 1'b1;
        cal_wa   = caddr(rank_q, f_q);
        cal_wd   = cal_rd_b_q;
      end
      S_SW_WB: begin
        cal_we = 1'b1;
        cal_wa = caddr(best_q, f_q);
        cal_wd = cal_rd_a_q;
      end
      S_HDR: begin
        cal_ra_a = caddr(rank_q, f_q);
      end
      S_CALL: begin
        cal_ra_a = caddr(rank_q, f_inc);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_wa] <= hdr_wd;
    end
    hdr_rd_q <= hdr_mem[hdr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cal_we) begin
      cal_mem[cal_wa] <= cal_wd;
    end
    cal_rd_a_q <= cal_mem[cal_ra_a];
    cal_rd_b_q <= cal_mem[cal_ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) begin
      pcall_q[plen_q[FIW-1:0]] <= item_i.frame_address;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_on_q  <= 1'b0;
      filt_pid_q <= '0;
      limit_q    <= ccf_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ccf_pkg::CFG_PID_FILTER_ON: filt_on_q  <= cfg_data_i[0];
        ccf_pkg::CFG_PID_FILTER:    filt_pid_q <= cfg_data_i;
        ccf_pkg::CFG_CHAIN_LIMIT:   limit_q    <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rank_q      <= '0;
      e_q         <= '0;
      best_q      <= '0;
      f_q         <= '0;
      plen_q      <= '0;
      ppid_q      <= '0;
      psym_q      <= '0;
      poff_q      <= '0;
      total_q     <= '0;
      unfold_q    <= '0;
      bhdr_q      <= '0;
      rhdr_q      <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (item_i.action)
              ccf_pkg::ACT_SAMPLE: begin
                if (plen_q == '0) begin
                  ppid_q <= item_i.pid;
                  psym_q <= item_i.leaf_symbol;
                  poff_q <= item_i.leaf_offset;
                  plen_q <= FW'(1);
                end else if (plen_q < FW'(MAX_FRAMES)) begin
                  plen_q <= plen_q + FW'(1);
                end
                if (item_i.last_frame) begin
                  state_q <= S_FOLD;
                end
              end
              ccf_pkg::ACT_REPORT: begin
                state_q <= S_REP;
              end
              ccf_pkg::ACT_CLEAR: begin
                used_q   <= '0;
                total_q  <= '0;
                unfold_q <= '0;
                rank_q   <= '0;
                plen_q   <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_FOLD: begin
          if (filt_on_q && ppid_q != filt_pid_q) begin
            plen_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            total_q <= sat_inc(total_q);
            e_q     <= '0;
            state_q <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          state_q <= (e_q == used_q) ? S_MISS : S_SC_CMP;
        end
        S_SC_CMP: begin
          bhdr_q <= hdr_rd_q;
          if (hdr_rd_q.depth == plen_q && hdr_rd_q.symbol == psym_q) begin
            f_q     <= FW'(1);
            state_q <= (plen_q == FW'(1)) ? S_HIT : S_CL_RD;
          end else begin
            e_q     <= e_q + UW'(1);
            state_q <= S_SC_RD;
          end
        end
        S_CL_RD: begin
          state_q <= S_CL_CMP;
        end
        S_CL_CMP: begin
          if (cal_rd_a_q == pcall_q[f_q[FIW-1:0]]) begin
            f_q     <= f_inc;
            state_q <= (f_inc == plen_q) ? S_HIT : S_CL_RD;
          end else begin
            e_q     <= e_q + UW'(1);
            state_q <= S_SC_RD;
          end
        end
        S_HIT: begin
          plen_q  <= '0;
          state_q <= S_IDLE;
        end
        S_MISS: begin
          f_q <= FW'(1);
          if (CW'(used_q) >= CW'(MAX_ENTRIES)) begin
            unfold_q <= sat_inc(unfold_q);
            plen_q   <= '0;
            state_q  <= S_IDLE;
          end else if (plen_q == FW'(1)) begin
            used_q  <= used_q + UW'(1);
            plen_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CP;
          end
        end
        S_CP: begin
          f_q <= f_inc;
          if (f_inc == plen_q) begin
            used_q  <= used_q + UW'(1);
            plen_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        S_REP: begin
          if (rep_done) begin
            res_valid_q <= 1'b1;
            res_q       <= '{kind: ccf_pkg::KIND_DONE, total_seen: total_q,
                             unfolded_seen: unfold_q, last: 1'b1, default: '0};
            rank_q      <= '0;
            state_q     <= S_IDLE;
          end else begin
            e_q     <= rank_q + UW'(1);
            best_q  <= rank_q;
            state_q <= S_SEL0;
          end
        end
        S_SEL0: begin
          rhdr_q  <= hdr_rd_q;
          bhdr_q  <= hdr_rd_q;
          state_q <= S_SEL_RD;
        end
        S_SEL_RD: begin
          if (e_q == used_q) begin
            state_q <= (best_q == rank_q) ? S_MUL : S_SW_H1;
          end else begin
            state_q <= S_SEL_CMP;
          end
        end
        S_SEL_CMP: begin
          if (hdr_rd_q.hits > bhdr_q.hits) begin
            bhdr_q <= hdr_rd_q;
            best_q <= e_q;
          end
          e_q     <= e_q + UW'(1);
          state_q <= S_SEL_RD;
        end
        S_SW_H1: begin
          state_q <= S_SW_H2;
        end
        S_SW_H2: begin
          f_q     <= FW'(1);
          state_q <= (MAX_FRAMES > 1) ? S_SW_RD : S_MUL;
        end
        S_SW_RD: begin
          state_q <= S_SW_WA;
        end
        S_SW_WA: begin
          state_q <= S_SW_WB;
        end
        S_SW_WB: begin
          if (f_inc == FW'(MAX_FRAMES)) begin
            state_q <= S_MUL;
          end else begin
            f_q     <= f_inc;
            state_q <= S_SW_RD;
          end
        end
        S_MUL: begin
          dvd_q   <= PW'(bhdr_q.hits) * PW'(ccf_pkg::PERMILLE_SCALE);
          rem_q   <= '0;
          dcnt_q  <= 6'(PW - 1);
          f_q     <= FW'(1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= ge ? 32'(trial - {1'b0, total_q}) : trial[31:0];
          dvd_q <= {dvd_q[PW-2:0], ge};
          if (dcnt_q == '0) begin
            state_q <= S_HDR;
          end else begin
            dcnt_q <= dcnt_q - 6'd1;
          end
        end
        S_HDR: begin
          res_valid_q <= 1'b1;
          res_q       <= '{kind: ccf_pkg::KIND_HEADER, chain_depth: 5'(dsel),
                           hits: bhdr_q.hits, permille: pm,
                           symbol_out: bhdr_q.symbol, offset_low: bhdr_q.low,
                           offset_high: bhdr_q.high, last: (dsel == FW'(1)),
                           default: '0};
          if (dsel == FW'(1)) begin
            rank_q  <= rank_q + UW'(1);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CALL;
          end
        end
        S_CALL: begin
          res_valid_q <= 1'b1;
          res_q       <= '{kind: ccf_pkg::KIND_CALLER, caller_address: cal_rd_a_q,
                           last: (f_inc == dsel), default: '0};
          f_q         <= f_inc;
          if (f_inc == dsel) begin
            rank_q  <= rank_q + UW'(1);
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more entries than it has rows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(used_q) <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  // The report position never passes the filled part of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_q <= used_q)
    else $error("report rank beyond used entries");

  // The pending sample never records more frames than the depth limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= FW'(MAX_FRAMES))
    else $error("pending sample longer than frame limit");

  // A result is only produced by a state that was working on an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q != S_IDLE))
    else $error("result without an item in progress");

  // A header never reports a share above one thousand permille.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind == ccf_pkg::KIND_HEADER) |-> (res_q.permille <= 10'd1000))
    else $error("permille out of range");

endmodule

`default_nettype wire

// File: tb/tb_call_chain_fold_table.sv
// ----------------------------------------------------------------------------
// tb_call_chain_fold_table
// Drives stack samples, reports, clears and register writes into the call
// chain fold table. An internal model of the table predicts every result,
// and a monitor compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_call_chain_fold_table;

  localparam int unsigned N_ENTRIES   = 256;
  localparam int unsigned N_FRAMES    = 16;
  localparam int unsigned DRAIN_CYC   = 9000;
  localparam longint      CYCLE_LIMIT = 6000000;
  localparam int unsigned IN_W        = $bits(ccf_pkg::in_t);

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  ccf_pkg::in_t                   item_i;
  logic                           result_valid_o;
  ccf_pkg::out_t                  result_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [1:0]                     cfg_index_i;
  logic [ccf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  call_chain_fold_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Table model state.
  logic        filter_on;
  logic [15:0] filter_pid;
  logic [8:0]  report_limit;
  logic [4:0]  tbl_depth  [N_ENTRIES];
  logic [15:0] tbl_symbol [N_ENTRIES];
  logic [31:0] tbl_low    [N_ENTRIES];
  logic [31:0] tbl_high   [N_ENTRIES];
  logic [31:0] tbl_hits   [N_ENTRIES];
  logic [63:0] tbl_callers[N_ENTRIES][N_FRAMES];
  int unsigned tbl_used;
  logic [63:0] cur_callers[N_FRAMES];
  int unsigned cur_len;
  logic [15:0] cur_pid;
  logic [15:0] cur_symbol;
  logic [31:0] cur_offset;
  logic [31:0] total_samples;
  logic [31:0] unfolded_samples;
  int unsigned next_rank;

  ccf_pkg::out_t expected_results[$];
  int unsigned   mismatch_count;
  longint        cycle_count = 0;
  bit            idle_enable;

  // Pool of known chains so that random samples fold onto existing entries.
  int unsigned pool_depth [8];
  logic [15:0] pool_symbol[8];
  logic [63:0] pool_addr  [8][N_FRAMES];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void fold_sample();
    int unsigned e;
    int unsigned f;
    bit          hit;
    if (filter_on && cur_pid != filter_pid) return;
    total_samples = sat_inc32(total_samples);
    hit = 1'b0;
    for (e = 0; e < tbl_used; e++) begin
      if (tbl_depth[e] == cur_len && tbl_symbol[e] == cur_symbol) begin
        hit = 1'b1;
        for (f = 1; f < cur_len; f++)
          if (tbl_callers[e][f] != cur_callers[f]) hit = 1'b0;
        if (hit) break;
      end
    end
    if (!hit) begin
      if (tbl_used >= N_ENTRIES) begin
        unfolded_samples = sat_inc32(unfolded_samples);
        return;
      end
      e = tbl_used;
      tbl_depth[e]  = cur_len[4:0];
      tbl_symbol[e] = cur_symbol;
      for (f = 1; f < cur_len; f++) tbl_callers[e][f] = cur_callers[f];
      tbl_hits[e] = '0;
      tbl_low[e]  = cur_offset;
      tbl_high[e] = cur_offset;
      tbl_used++;
    end
    if (cur_offset < tbl_low[e]) tbl_low[e] = cur_offset;
    if (cur_offset > tbl_high[e]) tbl_high[e] = cur_offset;
    tbl_hits[e] = sat_inc32(tbl_hits[e]);
  endfunction

  function automatic void swap_rows(input int unsigned a, input int unsigned b);
    logic [4:0]  d;
    logic [15:0] s;
    logic [31:0] w;
    logic [63:0] c;
    d = tbl_depth[a];  tbl_depth[a]  = tbl_depth[b];  tbl_depth[b]  = d;
    s = tbl_symbol[a]; tbl_symbol[a] = tbl_symbol[b]; tbl_symbol[b] = s;
    w = tbl_low[a];    tbl_low[a]    = tbl_low[b];    tbl_low[b]    = w;
    w = tbl_high[a];   tbl_high[a]   = tbl_high[b];   tbl_high[b]   = w;
    w = tbl_hits[a];   tbl_hits[a]   = tbl_hits[b];   tbl_hits[b]   = w;
    for (int unsigned f = 0; f < N_FRAMES; f++) begin
      c = tbl_callers[a][f]; tbl_callers[a][f] = tbl_callers[b][f]; tbl_callers[b][f] = c;
    end
  endfunction

  // One selection step: pick the hottest remaining chain and queue its results.
  function automatic void predict_report();
    int unsigned   best;
    int unsigned   d;
    logic [63:0]   pm;
    ccf_pkg::out_t r;
    r = '0;
    if (next_rank >= tbl_used || next_rank >= report_limit) begin
      r.kind          = ccf_pkg::KIND_DONE;
      r.total_seen    = total_samples;
      r.unfolded_seen = unfolded_samples;
      r.last          = 1'b1;
      expected_results.push_back(r);
      next_rank = 0;
      return;
    end
    best = next_rank;
    for (int unsigned j = next_rank + 1; j < tbl_used; j++)
      if (tbl_hits[j] > tbl_hits[best]) best = j;
    if (best != next_rank) swap_rows(next_rank, best);
    d = tbl_depth[next_rank];
    if (d < 1 || d > N_FRAMES) d = 1;
    pm = (total_samples == 0) ? 64'd0 :
         (64'(tbl_hits[next_rank]) * ccf_pkg::PERMILLE_SCALE) / total_samples;
    if (pm > ccf_pkg::PERMILLE_SCALE) pm = ccf_pkg::PERMILLE_SCALE;
    r.kind        = ccf_pkg::KIND_HEADER;
    r.chain_depth = d[4:0];
    r.hits        = tbl_hits[next_rank];
    r.permille    = pm[9:0];
    r.symbol_out  = tbl_symbol[next_rank];
    r.offset_low  = tbl_low[next_rank];
    r.offset_high = tbl_high[next_rank];
    r.last        = (d == 1);
    expected_results.push_back(r);
    for (int unsigned f = 1; f < d; f++) begin
      r = '0;
      r.kind           = ccf_pkg::KIND_CALLER;
      r.caller_address = tbl_callers[next_rank][f];
      r.last           = (f + 1 == d);
      expected_results.push_back(r);
    end
    next_rank++;
  endfunction

  function automatic void predict_item(input ccf_pkg::in_t it);
    case (it.action)
      ccf_pkg::ACT_SAMPLE: begin
        if (cur_len == 0) begin
          cur_pid    = it.pid;
          cur_symbol = it.leaf_symbol;
          cur_offset = it.leaf_offset;
          cur_len    = 1;
        end else if (cur_len < N_FRAMES) begin
          cur_callers[cur_len] = it.frame_address;
          cur_len++;
        end
        if (it.last_frame) begin
          fold_sample();
          cur_len = 0;
        end
      end
      ccf_pkg::ACT_REPORT: predict_report();
      ccf_pkg::ACT_CLEAR: begin
        tbl_used         = 0;
        total_samples    = '0;
        unfolded_samples = '0;
        next_rank        = 0;
        cur_len          = 0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    ccf_pkg::out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("kind", result_o.kind, want.kind);
        check_field("chain_depth", result_o.chain_depth, want.chain_depth);
        check_field("hits", result_o.hits, want.hits);
        check_field("permille", result_o.permille, want.permille);
        check_field("symbol_out", result_o.symbol_out, want.symbol_out);
        check_field("offset_low", result_o.offset_low, want.offset_low);
        check_field("offset_high", result_o.offset_high, want.offset_high);
        check_field("caller_address", result_o.caller_address, want.caller_address);
        check_field("total_seen", result_o.total_seen, want.total_seen);
        check_field("unfolded_seen", result_o.unfolded_seen, want.unfolded_seen);
        check_field("last", result_o.last, want.last);
      end
    end
  end

  // Start stays high across back-to-back items; it is only lowered for a gap.
  task automatic send_item(input ccf_pkg::in_t it);
    if (idle_enable && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_item(it);
  endtask

  task automatic send_action(input logic [1:0] act);
    ccf_pkg::in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.action = act;
    send_item(it);
  endtask

  task automatic send_sample(input logic [15:0] pid, input logic [15:0] sym,
                             input logic [31:0] off, input int unsigned frames,
                             input logic [63:0] addrs[N_FRAMES]);
    ccf_pkg::in_t it;
    for (int unsigned i = 0; i < frames; i++) begin
      it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.action      = ccf_pkg::ACT_SAMPLE;
      it.pid         = pid;
      it.leaf_symbol = sym;
      it.leaf_offset = off;
      if (i > 0 && i < N_FRAMES) it.frame_address = addrs[i];
      it.last_frame  = (i + 1 == frames);
      send_item(it);
    end
  endtask

  task automatic send_random_sample(input logic [15:0] pid, input int unsigned frames);
    logic [63:0] addrs[N_FRAMES];
    foreach (addrs[i]) addrs[i] = {$urandom, $urandom};
    send_sample(pid, 16'($urandom), $urandom, frames, addrs);
  endtask

  // Wait for every outstanding result, then for any fold still in progress.
  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ccf_pkg::CFG_PID_FILTER_ON: filter_on    = data[0];
      ccf_pkg::CFG_PID_FILTER:    filter_pid   = data;
      ccf_pkg::CFG_CHAIN_LIMIT:   report_limit = data[8:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    logic [63:0] addrs[N_FRAMES];
    foreach (addrs[i]) addrs[i] = (i % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
    send_action(ccf_pkg::ACT_REPORT);             // empty table: done with zero total
    send_sample(16'h0000, 16'h0000, 32'h0, 1, addrs);
    send_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 3, addrs);
    send_sample(16'h1234, 16'hFFFF, 32'h0, 3, addrs);  // same chain, wider span
    send_sample(16'h0001, 16'h0042, 32'h10, 18, addrs); // deeper than the limit
    send_action(ccf_pkg::ACT_RESERVED);
    send_action(ccf_pkg::ACT_REPORT);
    send_action(ccf_pkg::ACT_REPORT);
    send_action(ccf_pkg::ACT_REPORT);
    send_action(ccf_pkg::ACT_REPORT);
    send_action(ccf_pkg::ACT_REPORT);             // starts a new pass
    // A new chain added mid-pass is picked up by the next report.
    send_sample(16'h7, 16'h55, 32'h20, 1, addrs);
    send_action(ccf_pkg::ACT_REPORT);
    send_action(ccf_pkg::ACT_CLEAR);              // discards nothing pending here
    send_action(ccf_pkg::ACT_REPORT);
  endtask

  task automatic test_split_sample();
    ccf_pkg::in_t it;
    it = '0;
    it.action = ccf_pkg::ACT_SAMPLE; it.pid = 16'h9; it.leaf_symbol = 16'h77;
    it.leaf_offset = 32'h5;
    send_item(it);
    send_action(ccf_pkg::ACT_REPORT);
    it.frame_address = 64'h8000_0000_0000_0001; it.last_frame = 1'b1;
    send_item(it);
    it.last_frame = 1'b0;
    send_item(it);                                // pending, then cleared
    send_action(ccf_pkg::ACT_CLEAR);
    send_action(ccf_pkg::ACT_REPORT);
    send_action(ccf_pkg::ACT_REPORT);
  endtask

  task automatic test_pid_filter();
    write_reg(ccf_pkg::CFG_PID_FILTER, 16'hFFFF);
    write_reg(ccf_pkg::CFG_PID_FILTER_ON, 16'h1);
    send_random_sample(16'hFFFF, 2);
    send_random_sample(16'h7FFF, 2);
    send_random_sample(16'hFFFF, 1);
    repeat (3) send_action(ccf_pkg::ACT_REPORT);
    write_reg(ccf_pkg::CFG_PID_FILTER, 16'h0000);
    send_random_sample(16'h0000, 4);
    send_random_sample(16'h0001, 1);
    repeat (4) send_action(ccf_pkg::ACT_REPORT);
    write_reg(ccf_pkg::CFG_PID_FILTER_ON, 16'h0);
  endtask

  task automatic test_chain_limit();
    write_reg(ccf_pkg::CFG_CHAIN_LIMIT, 16'd0);
    send_random_sample(16'($urandom), 2);
    send_action(ccf_pkg::ACT_REPORT);
    write_reg(ccf_pkg::CFG_CHAIN_LIMIT, 16'd1);
    send_random_sample(16'($urandom), 1);
    repeat (3) send_action(ccf_pkg::ACT_REPORT);
    write_reg(ccf_pkg::CFG_CHAIN_LIMIT, 16'd256);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    int unsigned roll;
    foreach (pool_depth[i]) begin
      pool_depth[i]  = $urandom_range(1, N_FRAMES);
      pool_symbol[i] = 16'($urandom);
      foreach (pool_addr[i][j]) pool_addr[i][j] = {$urandom, $urandom};
    end
    sent = 0;
    while (sent < n_items) begin
      // A stretch in the middle runs with no gaps at all.
      idle_enable = !(sent > n_items / 3 && sent < n_items / 2);
      roll = $urandom_range(99);
      if (roll < 55) begin
        k = $urandom_range(7);
        send_sample(($urandom_range(3) == 0) ? 16'($urandom) : 16'h00AB,
                    pool_symbol[k], $urandom, pool_depth[k], pool_addr[k]);
        sent += pool_depth[k];
      end else if (roll < 67) begin
        k = $urandom_range(1, 18);
        send_random_sample(16'($urandom), k);
        sent += k;
      end else if (roll < 90) begin
        k = $urandom_range(1, 3);
        repeat (k) send_action(ccf_pkg::ACT_REPORT);
        sent += k;
      end else if (roll < 93) begin
        send_action(ccf_pkg::ACT_CLEAR);
        sent++;
      end else begin
        send_action(($urandom_range(1) == 0) ? ccf_pkg::ACT_RESERVED : ccf_pkg::ACT_SAMPLE);
        sent++;
      end
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_full_table();
    logic [63:0] addrs[N_FRAMES];
    foreach (addrs[i]) addrs[i] = '0;
    send_action(ccf_pkg::ACT_CLEAR);
    for (int unsigned i = 0; i < N_ENTRIES + 4; i++)
      send_sample(16'($urandom), 16'(i), $urandom, 1, addrs);
    send_sample(16'h3, 16'd5, 32'h0, 1, addrs);
    write_reg(ccf_pkg::CFG_CHAIN_LIMIT, 16'd2);
    repeat (4) send_action(ccf_pkg::ACT_REPORT);
    write_reg(ccf_pkg::CFG_CHAIN_LIMIT, 16'd256);
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    item_i         = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = ccf_pkg::CFG_PID_FILTER_ON;
    cfg_data_i     = '0;
    mismatch_count = 0;
    idle_enable    = 1'b1;
    filter_on      = 1'b0;
    filter_pid     = '0;
    report_limit   = ccf_pkg::LIMIT_RESET;
    tbl_used       = 0;
    cur_len        = 0;
    total_samples  = '0;
    unfolded_samples = '0;
    next_rank      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_split_sample();
    test_pid_filter();
    test_chain_limit();
    test_random(50);
    drain();
    test_full_table();

    drain();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/ccf_pkg.sv
rtl/call_chain_fold_table.sv
tb/tb_call_chain_fold_table.sv
